/* hdl/rmts_pkg.sv */
// Package: shared constants, register codes and the result record of the tick scheduler.
package rmts_pkg;

   localparam int MAX_TASKS_DEFAULT = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 3;
   localparam int PERIOD_W   = 16;
   localparam int BUDGET_W   = 16;
   localparam int TIME_W     = 32;
   localparam int TASK_NUM_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_THREE = 3'd4;

   typedef struct packed {
      logic                  idle;
      logic [TASK_NUM_W-1:0] task_number;
      logic [TIME_W-1:0]     tick_time;
   } rmts_result_type;

endpackage

/* hdl/rmts_sched.sv */
// Scheduler core: task registers, per-slot phase and budget state, grant selection.
module rmts_sched #(
   parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rmts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rmts_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             push,
   input  logic                             restart,
   output rmts_pkg::rmts_result_type        result
);
   import rmts_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_TASKS);

   logic [COUNT_W-1:0]                     count_ff;
   logic [COUNT_W-1:0]                     count_eff;
   logic [MAX_TASKS-1:0][CSR_DATA_W-1:0]   task_ff;
   logic [MAX_TASKS-1:0][BUDGET_W-1:0]     work_ff;
   logic [MAX_TASKS-1:0][BUDGET_W-1:0]     work_in;
   logic [MAX_TASKS-1:0][PERIOD_W-1:0]     phase_ff;
   logic [MAX_TASKS-1:0][PERIOD_W-1:0]     phase_in;
   logic [MAX_TASKS-1:0][PERIOD_W-1:0]     period;
   logic [MAX_TASKS-1:0][BUDGET_W-1:0]     work_eff;
   logic [MAX_TASKS-1:0]                   active;
   logic [MAX_TASKS-1:0]                   cand;
   logic [MAX_TASKS-1:0]                   grant;
   logic [TIME_W-1:0]                      time_ff;
   logic [TIME_W-1:0]                      time_now;
   logic                                   found;
   logic [PERIOD_W-1:0]                    best_period;
   logic [TASK_NUM_W-1:0]                  best_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we && csr_index == CSR_TASK_COUNT) begin
         count_ff <= csr_data[COUNT_W-1:0];
      end
   end

   assign count_eff = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign time_now  = restart ? '0 : time_ff;

   for (genvar s = 0; s < MAX_TASKS; s++) begin : g_slot
      logic [PERIOD_W-1:0] phase_eff;
      logic [PERIOD_W:0]   phase_inc;

      always_ff @(posedge clock) begin
         if (reset) begin
            task_ff[s] <= '0;
         end else if (csr_we && csr_index == CSR_IDX_W'(CSR_TASK_ZERO + s)) begin
            task_ff[s] <= csr_data;
         end
      end

      assign period[s]   = task_ff[s][CSR_DATA_W-1:BUDGET_W];
      assign active[s]   = (COUNT_W'(s) < count_eff) && (period[s] != '0);
      assign phase_eff   = restart ? '0 : phase_ff[s];
      assign work_eff[s] = (phase_eff == '0) ? task_ff[s][BUDGET_W-1:0] : work_ff[s];
      assign cand[s]     = active[s] && (work_eff[s] != '0);
      assign phase_inc   = {1'b0, phase_eff} + (PERIOD_W+1)'(1);

      always_comb begin
         if (!active[s]) begin
            work_in[s]  = '0;
            phase_in[s] = '0;
         end else begin
            work_in[s]  = grant[s] ? work_eff[s] - BUDGET_W'(1) : work_eff[s];
            phase_in[s] = (phase_inc >= {1'b0, period[s]}) ? '0 : phase_inc[PERIOD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            work_ff[s]  <= '0;
            phase_ff[s] <= '0;
         end else if (push) begin
            work_ff[s]  <= work_in[s];
            phase_ff[s] <= phase_in[s];
         end
      end
   end

   always_comb begin
      found       = 1'b0;
      best_period = '0;
      best_num    = '0;
      grant       = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (cand[i] && (!found || period[i] < best_period)) begin
            found       = 1'b1;
            best_period = period[i];
            best_num    = TASK_NUM_W'(i + 1);
            grant       = '0;
            grant[i]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (push) begin
         time_ff <= time_now + TIME_W'(1);
      end
   end

   assign result.idle        = !found;
   assign result.task_number = best_num;
   assign result.tick_time   = time_now;

   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant))
      else $error("more than one slot granted");

   a_time_advance: assert property (@(posedge clock) disable iff (reset)
      push && !restart |=> time_ff == $past(time_ff) + TIME_W'(1))
      else $error("tick time did not advance");

   a_grant_matches: assert property (@(posedge clock) disable iff (reset)
      found |-> grant != '0 && (grant & cand) == grant)
      else $error("granted slot has no work");

endmodule

/* hdl/rmts_out.sv */
// Result stage: output register with a skid entry that takes one more request under stall.
module rmts_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rmts_pkg::rmts_result_type   push_data,
   output logic                        full,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rmts_pkg::rmts_result_type   rsp_data
);
   import rmts_pkg::*;

   logic            main_valid_ff;
   logic            skid_valid_ff;
   rmts_result_type main_ff;
   rmts_result_type skid_ff;
   logic            pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without main entry");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("request pushed into full result stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

/* hdl/rate_monotonic_tick_scheduler_unit.sv */
// Top level: rate-monotonic tick scheduler with request, response and register channels.
//
//   channel | ports                                          | handshake
//   req     | req_valid, req_stall, req_restart              | valid & !stall
//   rsp     | rsp_valid, rsp_stall, rsp_idle,                | valid & !stall
//           | rsp_task_number, rsp_tick_time                 |
//   csr     | csr_valid, csr_ready, csr_index, csr_data      | valid & ready
//
// One request per cycle while req_stall is low; its response is registered in rmts_out.
// The grant is a four-way shortest-period compare on the slot state, done combinationally.
// Synchronous reset clears task registers, phases, budgets, time and the response stage.
// Response stall is absorbed by one skid entry; req_stall rises only when that entry is full.
// Register writes are always taken (csr_ready is held high).
module rate_monotonic_tick_scheduler_unit #(
   parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_idle,
   output logic [rmts_pkg::TASK_NUM_W-1:0]   rsp_task_number,
   output logic [rmts_pkg::TIME_W-1:0]       rsp_tick_time,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmts_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rmts_pkg::*;

   logic            req_accept;
   logic            full;
   rmts_result_type result;
   rmts_result_type rsp_data;

   assign csr_ready  = 1'b1;
   assign req_stall  = full;
   assign req_accept = req_valid && !full;

   rmts_sched #(
      .MAX_TASKS (MAX_TASKS)
   ) u_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (req_accept),
      .restart   (req_restart),
      .result    (result)
   );

   rmts_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_idle        = rsp_data.idle;
   assign rsp_task_number = rsp_data.task_number;
   assign rsp_tick_time   = rsp_data.tick_time;

endmodule

/* test/rmts_schedule_checker.sv */
`timescale 1ns / 1ps
// Checker: mirrors the scheduler's slot state and compares each response with the predicted grant.
module rmts_schedule_checker #(
   parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_restart,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_idle,
   input  logic [rmts_pkg::TASK_NUM_W-1:0] rsp_task_number,
   input  logic [rmts_pkg::TIME_W-1:0]     rsp_tick_time,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [rmts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rmts_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              outstanding
);
   import rmts_pkg::*;

   logic [COUNT_W-1:0]    slots_in_use;
   logic [CSR_DATA_W-1:0] slot_word [4];
   logic [BUDGET_W-1:0]   work_left [4];
   logic [PERIOD_W-1:0]   slot_phase [4];
   logic [TIME_W-1:0]     now_time;
   rmts_result_type       grant_queue [$];
   int                    failures;

   task automatic schedule_tick(input logic restart, output rmts_result_type grant);
      int                  active;
      int                  chosen;
      logic [PERIOD_W-1:0] best_period;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W:0]   next_phase;
      active = (slots_in_use > MAX_TASKS) ? MAX_TASKS : slots_in_use;
      if (active > 4) active = 4;
      chosen = -1;
      best_period = '0;
      if (restart) begin
         now_time = '0;
         for (int i = 0; i < 4; i++) slot_phase[i] = '0;
      end
      grant.tick_time = now_time;
      for (int i = 0; i < 4; i++) begin
         period = slot_word[i][31:16];
         if (i >= active || period == 0) begin
            work_left[i] = '0;
            slot_phase[i] = '0;
         end else begin
            if (slot_phase[i] == 0) work_left[i] = slot_word[i][15:0];
            if (work_left[i] != 0 && (chosen < 0 || period < best_period)) begin
               chosen = i;
               best_period = period;
            end
         end
      end
      if (chosen >= 0) begin
         work_left[chosen] = work_left[chosen] - 1'b1;
         grant.idle = 1'b0;
         grant.task_number = TASK_NUM_W'(chosen + 1);
      end else begin
         grant.idle = 1'b1;
         grant.task_number = '0;
      end
      for (int i = 0; i < active; i++) begin
         period = slot_word[i][31:16];
         if (period != 0) begin
            next_phase = {1'b0, slot_phase[i]} + 1'b1;
            if (next_phase >= {1'b0, period}) next_phase = '0;
            slot_phase[i] = next_phase[PERIOD_W-1:0];
         end
      end
      now_time = now_time + 1'b1;
   endtask

   always @(posedge clock) begin
      rmts_result_type grant;
      rmts_result_type want;
      if (reset) begin
         slots_in_use = '0;
         for (int i = 0; i < 4; i++) begin
            slot_word[i] = '0;
            work_left[i] = '0;
            slot_phase[i] = '0;
         end
         now_time = '0;
         grant_queue.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TASK_COUNT: slots_in_use = csr_data[COUNT_W-1:0];
               CSR_TASK_ZERO:  slot_word[0] = csr_data;
               CSR_TASK_ONE:   slot_word[1] = csr_data;
               CSR_TASK_TWO:   slot_word[2] = csr_data;
               CSR_TASK_THREE: slot_word[3] = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected response idle=%0b task=%0d time=%0d",
                           $realtime, rsp_idle, rsp_task_number, rsp_tick_time);
            end else begin
               want = grant_queue.pop_front();
               if (want.idle !== rsp_idle || want.task_number !== rsp_task_number ||
                   want.tick_time !== rsp_tick_time) begin
                  failures++;
                  if (failures <= 10)
                     $display(
                        "%0t: expected idle=%0b task=%0d time=%0d, got idle=%0b task=%0d time=%0d",
                        $realtime, want.idle, want.task_number, want.tick_time,
                        rsp_idle, rsp_task_number, rsp_tick_time);
               end
            end
         end
         if (req_valid && !req_stall) begin
            schedule_tick(req_restart, grant);
            grant_queue.push_back(grant);
         end
      end
      fail_count <= failures;
      outstanding <= grant_queue.size();
   end

endmodule

/* test/tb_rate_monotonic_tick_scheduler_unit.sv */
`timescale 1ns / 1ps
// Testbench top: drives ticks and slot register writes into the scheduler and reports the verdict.
module tb_rate_monotonic_tick_scheduler_unit;
   import rmts_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_idle;
   logic [TASK_NUM_W-1:0] rsp_task_number;
   logic [TIME_W-1:0]     rsp_tick_time;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    outstanding;
   int                    cycle_count = 0;
   bit                    calm = 1'b0;

   rate_monotonic_tick_scheduler_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_idle        (rsp_idle),
      .rsp_task_number (rsp_task_number),
      .rsp_tick_time   (rsp_tick_time),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   rmts_schedule_checker grant_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_idle        (rsp_idle),
      .rsp_task_number (rsp_task_number),
      .rsp_tick_time   (rsp_tick_time),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 31);
   end

   task automatic send_tick(input logic restart);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(99) < 31) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_slots(input logic [COUNT_W-1:0] count,
                             input logic [3:0][CSR_DATA_W-1:0] words, input bit stray);
      write_reg(CSR_TASK_COUNT, {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'h7 | count);
      write_reg(CSR_TASK_ZERO, words[0]);
      write_reg(CSR_TASK_ONE, words[1]);
      write_reg(CSR_TASK_TWO, words[2]);
      write_reg(CSR_TASK_THREE, words[3]);
      if (stray) write_reg(CSR_IDX_W'($urandom_range(5, 7)), $urandom());
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_slot();
      logic [PERIOD_W-1:0] period;
      logic [BUDGET_W-1:0] budget;
      case ($urandom_range(9))
         0:       period = '0;
         1:       period = 16'hFFFF;
         2:       period = PERIOD_W'($urandom_range(1, 40));
         default: period = PERIOD_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(7))
         0:       budget = '0;
         1:       budget = 16'hFFFF;
         2:       budget = BUDGET_W'($urandom());
         default: budget = BUDGET_W'($urandom_range(1, 4));
      endcase
      if ($urandom_range(15) == 0) return $urandom();
      return {period, budget};
   endfunction

   initial begin
      logic [3:0][CSR_DATA_W-1:0] words;
      logic [COUNT_W-1:0]         count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no slots in use after reset
      send_tick(1'b0);
      send_tick(1'b1);
      settle();

      // oversized count, longest period and budget, zero period, zero budget
      words[0] = {16'd3, 16'd1};
      words[1] = 32'hFFFF_FFFF;
      words[2] = {16'd0, 16'd5};
      words[3] = {16'd5, 16'd0};
      load_slots(3'd7, words, 1'b1);
      for (int k = 0; k < 8; k++) send_tick(k == 0 || k == 6);
      settle();

      // lower the period below the running phase
      words = '0;
      words[0] = {16'd10, 16'd2};
      load_slots(3'd1, words, 1'b0);
      for (int k = 0; k < 5; k++) send_tick(k == 0);
      settle();
      words[0] = {16'd3, 16'd2};
      load_slots(3'd1, words, 1'b0);
      for (int k = 0; k < 3; k++) send_tick(1'b0);
      settle();

      // equal periods: lower slot wins
      words[0] = {16'd4, 16'd1};
      words[1] = {16'd4, 16'd2};
      words[2] = {16'd4, 16'd1};
      words[3] = {16'd2, 16'd0};
      load_slots(3'd4, words, 1'b0);
      for (int k = 0; k < 6; k++) send_tick(k == 0);
      settle();

      for (int phase_n = 0; phase_n < 11; phase_n++) begin
         calm = (phase_n == 4 || phase_n == 5);
         count = COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(1, 4));
         for (int s = 0; s < 4; s++) words[s] = random_slot();
         load_slots(count, words, $urandom_range(3) == 0);
         for (int k = 0; k < 100; k++) begin
            send_tick(k == 0 || $urandom_range(99) < 3);
            if (k == 50 && $urandom_range(1) == 1) settle();
         end
         settle();
      end
      calm = 1'b0;

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/rmts_pkg.sv
hdl/rmts_sched.sv
hdl/rmts_out.sv
hdl/rate_monotonic_tick_scheduler_unit.sv
test/rmts_schedule_checker.sv
test/tb_rate_monotonic_tick_scheduler_unit.sv
